>>> rtl/core/fdss_pkg.sv
package fdss_pkg;

    localparam int DIGITS      = 4;
    localparam int CONV_DIGITS = 4;
    localparam int VALUE_W     = 14;
    localparam int SEG_W       = 7;
    localparam int EN_W        = 4;
    localparam int POS_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = VALUE_W'(9999);

    typedef logic [3:0]       digit_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_SCAN  = 1'b1
    } op_t;

    // conversion result handed from the bcd splitter to the top level
    typedef struct packed {
        logic                         rejected;
        digit_t [CONV_DIGITS-1:0]     digits;
    } bcd_t;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [EN_W-1:0]  digit_enable;
        logic             drive;
        logic             rejected;
    } result_t;

    // hex glyphs, bit0 = a .. bit6 = g
    function automatic logic [SEG_W-1:0] seg_lookup(input digit_t d);
        logic [SEG_W-1:0] s;
        case (d)
            4'h0:    s = 7'h3F;
            4'h1:    s = 7'h06;
            4'h2:    s = 7'h5B;
            4'h3:    s = 7'h4F;
            4'h4:    s = 7'h66;
            4'h5:    s = 7'h6D;
            4'h6:    s = 7'h7D;
            4'h7:    s = 7'h07;
            4'h8:    s = 7'h7F;
            4'h9:    s = 7'h6F;
            4'hA:    s = 7'h77;
            4'hB:    s = 7'h7C;
            4'hC:    s = 7'h39;
            4'hD:    s = 7'h5E;
            4'hE:    s = 7'h79;
            default: s = 7'h71;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/fdss_bcd.sv
module fdss_bcd
    import fdss_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    output bcd_t               bcd
);

    // reciprocal multiplies, exact for every 14-bit value
    logic [29:0] p10;
    logic [26:0] p100;
    logic [27:0] p1000;
    logic [10:0] q10;
    logic [7:0]  q100;
    logic [4:0]  q1000;
    logic [13:0] r0;
    logic [10:0] r1;
    logic [7:0]  r2;

    assign p10   = 30'(value) * 30'd52429;
    assign p100  = 27'(value) * 27'd5243;
    assign p1000 = 28'(value) * 28'd8389;

    assign q10   = p10[29:19];
    assign q100  = p100[26:19];
    assign q1000 = p1000[27:23];

    assign r0 = value - 14'(q10) * 14'd10;
    assign r1 = q10   - 11'(q100) * 11'd10;
    assign r2 = q100  - 8'(q1000) * 8'd10;

    assign bcd.digits[0] = r0[3:0];
    assign bcd.digits[1] = r1[3:0];
    assign bcd.digits[2] = r2[3:0];
    assign bcd.digits[3] = q1000[3:0];
    assign bcd.rejected  = (value > VALUE_LIMIT);

endmodule

>>> rtl/core/fdss_decode.sv
module fdss_decode
    import fdss_pkg::*;
(
    input  digit_t           digit,
    input  pos_t             pos,
    output logic [SEG_W-1:0] segments,
    output logic [EN_W-1:0]  digit_enable
);

    assign segments = seg_lookup(digit);

    // positions past the enable field drive no line
    always_comb
    begin
        for (int k = 0; k < EN_W; k++)
        begin
            digit_enable[k] = (int'(pos) == k);
        end
    end

endmodule

>>> rtl/core/four_digit_seven_segment_scanner.sv
// pipeline: an accepted word is held in the input register stage, its result in the result register stage
// throughput: one word per cycle while m_tready is high, set by the single register pair around the
//   bcd splitter and the segment decode
// reset: rst_n low clears the digit store to zero, the scan position to digit 0
//   and both pipeline valid flags
module four_digit_seven_segment_scanner
    import fdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] value, [15:14] zero
    input  logic [0:0]  s_tuser,   // [0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] segments, [10:7] digit_enable, [15:11] zero
    output logic [1:0]  m_tuser    // [0] drive, [1] rejected
);

    // input register stage
    logic               in_valid_reg;
    logic               in_valid_next;
    op_t                in_op_reg;
    logic [VALUE_W-1:0] in_value_reg;

    // display state
    digit_t             store_reg  [DIGITS];
    digit_t             store_next [DIGITS];
    pos_t               pos_reg;
    pos_t               pos_next;

    // result register stage
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            out_next;

    logic               advance;
    bcd_t               bcd;
    logic [SEG_W-1:0]   seg_scan;
    logic [EN_W-1:0]    en_scan;

    // a word moves forward when the result slot is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    fdss_bcd u_bcd
    (
        .value (in_value_reg),
        .bcd   (bcd)
    );

    fdss_decode u_decode
    (
        .digit        (store_reg[pos_reg]),
        .pos          (pos_reg),
        .segments     (seg_scan),
        .digit_enable (en_scan)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        store_next = store_reg;
        pos_next   = pos_reg;
        out_next   = out_reg;

        if (advance)
        begin
            out_next = '0;
            case (in_op_reg)
                OP_WRITE:
                begin
                    out_next.rejected = bcd.rejected;
                    if (!bcd.rejected)
                    begin
                        // every slot is rewritten, leading zeros included
                        for (int k = 0; k < DIGITS; k++)
                        begin
                            if (k < CONV_DIGITS)
                            begin
                                store_next[k] = bcd.digits[k % CONV_DIGITS];
                            end
                            else
                            begin
                                store_next[k] = '0;
                            end
                        end
                    end
                end
                OP_SCAN:
                begin
                    out_next.segments     = seg_scan;
                    out_next.digit_enable = en_scan;
                    out_next.drive        = 1'b1;
                    if (pos_reg == POS_W'(DIGITS - 1))
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    out_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            for (int k = 0; k < DIGITS; k++)
            begin
                store_reg[k] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            store_reg     <= store_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= op_t'(s_tuser[0]);
            in_value_reg <= s_tdata[VALUE_W-1:0];
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.digit_enable, out_reg.segments};
    assign m_tuser  = {out_reg.rejected, out_reg.drive};

endmodule

>>> dv/tb_four_digit_seven_segment_scanner.sv
module tb_four_digit_seven_segment_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import fdss_pkg::*;

    // minimum number of words pushed into the slave side before the final drain
    localparam int unsigned TOTAL_WORDS = 1650;
    // words at the tail of the run sent with neither side idling
    localparam int unsigned CALM_TAIL   = 150;

    // ------------------------------------------------------------------
    // scoreboard: predicts the result word for each accepted input word
    // and holds the predictions until the master side delivers them
    // ------------------------------------------------------------------
    class scan_scoreboard;
        logic [SEG_W-1:0] glyph_rom [16];
        digit_t           digit_mem [DIGITS];
        int unsigned      scan_idx;
        result_t          pending_results [$];
        int unsigned      errors;

        function new();
            glyph_rom = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
                          7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71};
            foreach (digit_mem[k])
                digit_mem[k] = '0;
            scan_idx = 0;
            errors   = 0;
        endfunction

        // work out the result of one accepted word and advance the state
        function void note_word(op_t op, logic [VALUE_W-1:0] value);
            result_t     r;
            int unsigned n;
            r = '0;
            n = value;
            if (op == OP_WRITE)
            begin
                if (value > VALUE_LIMIT)
                    r.rejected = 1'b1;
                else
                begin
                    // all slots rewritten, leading zeros included
                    for (int k = 0; k < DIGITS; k++)
                    begin
                        digit_mem[k] = digit_t'(n % 10);
                        n = n / 10;
                    end
                end
            end
            else
            begin
                r.segments     = glyph_rom[digit_mem[scan_idx]];
                r.digit_enable = (scan_idx < EN_W) ? EN_W'(1 << scan_idx) : '0;
                r.drive        = 1'b1;
                scan_idx       = (scan_idx + 1 >= DIGITS) ? 0 : scan_idx + 1;
            end
            pending_results.push_back(r);
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // compare one delivered result word with the oldest prediction
        task check_word(logic [SEG_W-1:0] seg, logic [EN_W-1:0] en, logic drv, logic rej);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected word segments=%h enable=%b drive=%b rejected=%b",
                                 seg, en, drv, rej));
                return;
            end
            want = pending_results.pop_front();
            if (seg !== want.segments)
                report($sformatf("segments %h, want %h", seg, want.segments));
            if (en !== want.digit_enable)
                report($sformatf("digit_enable %b, want %b", en, want.digit_enable));
            if (drv !== want.drive)
                report($sformatf("drive %b, want %b", drv, want.drive));
            if (rej !== want.rejected)
                report($sformatf("rejected %b, want %b", rej, want.rejected));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [13:0] value, [15:14] zero
    logic [0:0]  s_tuser  = '0;    // [0] op

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [6:0] segments, [10:7] digit_enable, [15:11] zero
    logic [1:0]  m_tuser;          // [0] drive, [1] rejected

    scan_scoreboard sb = new();

    // sender idling chance in percent, changed every few dozen words
    int unsigned idle_pct   = 0;
    int unsigned words_sent = 0;
    // set for the tail of the run: both sides stop idling
    bit          quiet      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    four_digit_seven_segment_scanner u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // slave-side driver
    // ------------------------------------------------------------------

    // present one word, maybe after a random idle burst, and wait for the handshake
    task automatic send_word(op_t op, logic [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(16 - VALUE_W){1'b0}}, value};
        do @(posedge clk); while (!s_tready);
        // accepted at this edge
        sb.note_word(op, value);
        words_sent++;
    endtask

    // hold the sender off until every predicted word has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // master-side stall generator: ready runs of random length with
    // stall bursts of random length, no stalls in the calm tail
    // ------------------------------------------------------------------
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(100, 300)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                if (!quiet)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // master-side monitor: values read here are the ones before the edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata[6:0], m_tdata[10:7], m_tuser[0], m_tuser[1]);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned         next_regime;
        int unsigned         pick;
        logic [VALUE_W-1:0]  num;
        bit                  paused;

        next_regime = 50;
        paused      = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: scan straight after reset shows the cleared store
        send_word(OP_SCAN, '0);
        // zero fills every digit
        send_word(OP_WRITE, '0);
        repeat (3) send_word(OP_SCAN, '0);
        // largest accepted value, with all-ones in the ignored value field of scans
        send_word(OP_WRITE, 14'd9999);
        repeat (4) send_word(OP_SCAN, '1);
        // just above the limit and the field maximum: store must not change
        send_word(OP_WRITE, 14'd10000);
        send_word(OP_SCAN, '0);
        send_word(OP_WRITE, '1);
        // four distinct digits, then a short number that must clear the upper ones
        send_word(OP_WRITE, 14'd1234);
        repeat (4) send_word(OP_SCAN, '0);
        send_word(OP_WRITE, 14'd7);
        repeat (4) send_word(OP_SCAN, '0);

        // random: mostly a write followed by a scan sweep, some rejects and stray scans
        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent >= TOTAL_WORDS - CALM_TAIL)
                quiet = 1'b1;
            if (!paused && words_sent >= TOTAL_WORDS / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            if (words_sent >= next_regime)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
                next_regime += 50;
            end

            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // mix of number lengths so short writes over long ones get exercised
                case ($urandom_range(0, 3))
                    0:       num = VALUE_W'($urandom_range(0, 9));
                    1:       num = VALUE_W'($urandom_range(0, 99));
                    2:       num = VALUE_W'($urandom_range(0, 999));
                    default: num = VALUE_W'($urandom_range(0, 9999));
                endcase
                send_word(OP_WRITE, num);
                repeat ($urandom_range(1, 8)) send_word(OP_SCAN, VALUE_W'($urandom));
            end
            else if (pick < 80)
                send_word(OP_WRITE, VALUE_W'($urandom_range(10000, 16383)));
            else
                send_word(OP_SCAN, VALUE_W'($urandom));
        end

        // wait out the pipeline, then keep watching for stray words
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
